// File: design/tournament_branch_predictor_top_assert.svh
// Assertion macros shared by the tournament branch predictor.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_TOP_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_TOP_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define TBP_ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define TBP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tbp_pkg.sv
package tbp_pkg;

  localparam logic [1:0] CTR_RESET = 2'd1;
  localparam logic [1:0] CTR_MAX   = 2'd3;
  localparam logic [1:0] CTR_MIN   = 2'd0;

  // Status that the back end reports to the front end.
  typedef struct packed {
    logic clearing;
    logic busy;
  } back_status_t;

  function automatic logic [1:0] ctr_up(input logic [1:0] c);
    return (c == CTR_MAX) ? c : c + 2'd1;
  endfunction

  function automatic logic [1:0] ctr_down(input logic [1:0] c);
    return (c == CTR_MIN) ? c : c - 2'd1;
  endfunction

endpackage

// File: design/tbp_front.sv
module tbp_front #(
  parameter int BIMODAL_INDEX_BITS = 12,
  parameter int GSHARE_INDEX_BITS  = 12,
  parameter int CHOOSER_INDEX_BITS = 12,
  parameter int HISTORY_BITS       = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [63:0]          pc,
  input  logic                 taken,
  input  tbp_pkg::back_status_t status,
  input  logic                 q_full,
  output logic                 push,
  output logic [2+BIMODAL_INDEX_BITS+GSHARE_INDEX_BITS+CHOOSER_INDEX_BITS-1:0] entry
);

  // The global history lives here, so the gshare index is formed at accept time.
  logic [HISTORY_BITS-1:0] hist;
  logic [HISTORY_BITS:0]   hist_shift;
  logic [63:0]             gmix;

  assign in_ready   = !status.clearing && !q_full;
  assign push       = in_valid && in_ready;
  assign gmix       = pc ^ 64'(hist);
  assign hist_shift = {hist, taken};

  assign entry = {action, taken, pc[BIMODAL_INDEX_BITS-1:0],
                  gmix[GSHARE_INDEX_BITS-1:0], pc[CHOOSER_INDEX_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (push && action) begin
      hist <= hist_shift[HISTORY_BITS-1:0];
    end
  end

endmodule

// File: design/tbp_queue.sv
module tbp_queue #(
  parameter int WIDTH = 38
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  // Two-entry circular queue.
  logic [WIDTH-1:0] ent [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: design/tbp_back.sv
module tbp_back #(
  parameter int BIMODAL_INDEX_BITS = 12,
  parameter int GSHARE_INDEX_BITS  = 12,
  parameter int CHOOSER_INDEX_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  logic [2+BIMODAL_INDEX_BITS+GSHARE_INDEX_BITS+CHOOSER_INDEX_BITS-1:0] q_data,
  output logic                  q_pop,
  output tbp_pkg::back_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  prediction,
  output logic                  used_global
);

  localparam int BB = BIMODAL_INDEX_BITS;
  localparam int GB = GSHARE_INDEX_BITS;
  localparam int CB = CHOOSER_INDEX_BITS;
  localparam int MAXB = (BB > GB) ? ((BB > CB) ? BB : CB) : ((GB > CB) ? GB : CB);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] bim_mem [1 << BB];
  logic [1:0] gsh_mem [1 << GB];
  logic [1:0] cho_mem [1 << CB];

  logic [1:0]      state;
  logic [1:0]      state_next;
  logic [MAXB-1:0] clear_cnt;
  logic [MAXB-1:0] clear_cnt_next;

  logic          q_action;
  logic          q_taken;
  logic [BB-1:0] q_bi;
  logic [GB-1:0] q_gi;
  logic [CB-1:0] q_ci;

  logic          cur_action;
  logic          cur_taken;
  logic [BB-1:0] cur_bi;
  logic [GB-1:0] cur_gi;
  logic [CB-1:0] cur_ci;

  logic [1:0] bim_rd;
  logic [1:0] gsh_rd;
  logic [1:0] cho_rd;

  logic clearing;
  logic rd_en;
  logic fire;
  logic upd;
  logic bim_pred;
  logic gsh_pred;
  logic use_gsh;
  logic bim_ok;
  logic gsh_ok;

  logic          bim_we;
  logic [BB-1:0] bim_waddr;
  logic [1:0]    bim_wdata;
  logic          gsh_we;
  logic [GB-1:0] gsh_waddr;
  logic [1:0]    gsh_wdata;
  logic          cho_we;
  logic [CB-1:0] cho_waddr;
  logic [1:0]    cho_wdata;

  assign {q_action, q_taken, q_bi, q_gi, q_ci} = q_data;

  assign clearing        = (state == S_CLEAR);
  assign rd_en           = (state == S_IDLE) && q_valid;
  assign q_pop           = rd_en;
  assign status.clearing = clearing;
  assign status.busy     = (state == S_EXEC);

  assign bim_pred = bim_rd[1];
  assign gsh_pred = gsh_rd[1];
  assign use_gsh  = cho_rd[1];
  assign bim_ok   = (bim_pred == cur_taken);
  assign gsh_ok   = (gsh_pred == cur_taken);
  assign fire     = (state == S_EXEC) && (!out_valid || out_ready);
  assign upd      = fire && cur_action;

  // Write ports: the clearing sweep or the counter update of the current item.
  always_comb begin
    bim_we    = clearing || upd;
    gsh_we    = clearing || upd;
    cho_we    = clearing || (upd && (gsh_ok != bim_ok));
    bim_waddr = clearing ? clear_cnt[BB-1:0] : cur_bi;
    gsh_waddr = clearing ? clear_cnt[GB-1:0] : cur_gi;
    cho_waddr = clearing ? clear_cnt[CB-1:0] : cur_ci;
    if (clearing) begin
      bim_wdata = tbp_pkg::CTR_RESET;
      gsh_wdata = tbp_pkg::CTR_RESET;
      cho_wdata = tbp_pkg::CTR_RESET;
    end else begin
      bim_wdata = cur_taken ? tbp_pkg::ctr_up(bim_rd) : tbp_pkg::ctr_down(bim_rd);
      gsh_wdata = cur_taken ? tbp_pkg::ctr_up(gsh_rd) : tbp_pkg::ctr_down(gsh_rd);
      cho_wdata = gsh_ok ? tbp_pkg::ctr_up(cho_rd) : tbp_pkg::ctr_down(cho_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (bim_we) begin
      bim_mem[bim_waddr] <= bim_wdata;
    end
    if (rd_en) begin
      bim_rd <= bim_mem[q_bi];
    end
  end

  always_ff @(posedge clk) begin
    if (gsh_we) begin
      gsh_mem[gsh_waddr] <= gsh_wdata;
    end
    if (rd_en) begin
      gsh_rd <= gsh_mem[q_gi];
    end
  end

  always_ff @(posedge clk) begin
    if (cho_we) begin
      cho_mem[cho_waddr] <= cho_wdata;
    end
    if (rd_en) begin
      cho_rd <= cho_mem[q_ci];
    end
  end

  always_comb begin
    state_next     = state;
    clear_cnt_next = clear_cnt;
    case (state)
      S_CLEAR: begin
        clear_cnt_next = clear_cnt + MAXB'(1);
        if (clear_cnt == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clear_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clear_cnt <= clear_cnt_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_action <= q_action;
      cur_taken  <= q_taken;
      cur_bi     <= q_bi;
      cur_gi     <= q_gi;
      cur_ci     <= q_ci;
    end
    if (fire) begin
      prediction  <= use_gsh ? gsh_pred : bim_pred;
      used_global <= use_gsh;
    end
  end

endmodule

// File: design/tournament_branch_predictor_top.sv
// Tournament branch predictor combining a bimodal and a gshare component.
// The input channel (in_valid/in_ready) carries one item per transfer: action
// selects predict only or update, pc is the branch address, and taken is the
// resolved direction used by updates. The output channel (out_valid/out_ready)
// returns one result per item: prediction and used_global, both taken from
// the counter state as it was before that item's update.
// A front end accepts items, forms the three table indexes and keeps the
// global history; a two-entry queue separates it from the back end, which
// reads the counter tables, registers the result and writes the counters back.
// An accepted item passes the queue, the table read registers and then the
// output register. The back end takes no new item until it has finished the
// current one, which it reads from the tables, then computes and writes back.
// After reset the back end sweeps 2**max(index bits) addresses (4096 with the
// default sizes), one entry per cycle; in_ready stays low during the sweep
// and the history is cleared. When the receiver stalls, the result waits in
// the output register and the queue keeps taking transfers until it is full,
// after which in_ready drops.
`include "tournament_branch_predictor_top_assert.svh"

module tournament_branch_predictor_top #(
  parameter int BIMODAL_INDEX_BITS = 12,
  parameter int GSHARE_INDEX_BITS  = 12,
  parameter int CHOOSER_INDEX_BITS = 12,
  parameter int HISTORY_BITS       = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [63:0] pc,
  input  logic        taken,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        prediction,
  output logic        used_global
);

  // A queue entry holds action, taken and the three table indexes.
  localparam int ENTRY_W = 2 + BIMODAL_INDEX_BITS + GSHARE_INDEX_BITS + CHOOSER_INDEX_BITS;

  tbp_pkg::back_status_t status;
  logic                  push;
  logic [ENTRY_W-1:0]    entry;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [ENTRY_W-1:0]    q_data;

  tbp_front #(
    .BIMODAL_INDEX_BITS (BIMODAL_INDEX_BITS),
    .GSHARE_INDEX_BITS  (GSHARE_INDEX_BITS),
    .CHOOSER_INDEX_BITS (CHOOSER_INDEX_BITS),
    .HISTORY_BITS       (HISTORY_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .pc       (pc),
    .taken    (taken),
    .status   (status),
    .q_full   (q_full),
    .push     (push),
    .entry    (entry)
  );

  tbp_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .not_empty (q_valid)
  );

  tbp_back #(
    .BIMODAL_INDEX_BITS (BIMODAL_INDEX_BITS),
    .GSHARE_INDEX_BITS  (GSHARE_INDEX_BITS),
    .CHOOSER_INDEX_BITS (CHOOSER_INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .prediction  (prediction),
    .used_global (used_global)
  );

  // No input transfer may land while the tables are still being cleared.
  `TBP_ASSERT_NEVER(a_no_accept_clearing, clk, rst, push && status.clearing, "accept during clear")
  // The queue must never be written while full.
  `TBP_ASSERT_NEVER(a_no_push_full, clk, rst, push && q_full, "push into full queue")
  // The back end takes a new item only when it holds none.
  `TBP_ASSERT_NEVER(a_no_pop_busy, clk, rst, q_pop && status.busy, "pop while busy")
  // A popped item occupies the back end in the following cycle.
  `TBP_ASSERT_NEXT(a_pop_then_busy, clk, rst, q_pop, status.busy, "pop without busy")

endmodule
